FILE: rtl/core/sfe_pkg.sv
package sfe_pkg;

  localparam int MaxBytes = 6;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;

  localparam logic RegEscape = 1'b0;
  localparam logic RegStart  = 1'b1;

  localparam logic [7:0] EscapeReset = 8'h90;
  localparam logic [7:0] StartReset  = 8'h02;

  typedef struct packed {
    logic [7:0] escape_byte;
    logic [7:0] start_byte;
  } cfg_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     fin;
  } job_t;

  function automatic logic [15:0] crc_word(input logic [15:0] crc, input logic [15:0] w);
    logic [15:0] c;
    logic        carry;
    c = crc;
    for (int i = 15; i >= 0; i--) begin
      carry = (c & CrcTop) != 16'h0000;
      c = {c[14:0], w[i]};
      if (carry) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/sfe_cfg_if.sv
interface sfe_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/sfe_in_if.sv
interface sfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] even_byte;
  logic [7:0] odd_byte;
  logic       final_word;

  modport source (output valid, output even_byte, output odd_byte, output final_word,
                  input ready);
  modport sink (input valid, input even_byte, input odd_byte, input final_word,
                output ready);
endinterface

FILE: rtl/core/sfe_out_if.sv
interface sfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, output line_byte, output run_last, output frame_done,
                  input ready);
  modport sink (input valid, input line_byte, input run_last, input frame_done,
                output ready);
endinterface

FILE: rtl/core/sfe_cfg_regs.sv
module sfe_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  sfe_cfg_if.sink       cfg,
  output sfe_pkg::cfg_t cfg_regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.escape_byte <= sfe_pkg::EscapeReset;
      cfg_regs.start_byte  <= sfe_pkg::StartReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sfe_pkg::RegEscape: cfg_regs.escape_byte <= cfg.data;
        sfe_pkg::RegStart:  cfg_regs.start_byte  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/sfe_word_stage.sv
module sfe_word_stage (
  input  logic          clk,
  input  logic          rst,
  sfe_in_if.sink        word_in,
  input  sfe_pkg::cfg_t cfg_regs,
  input  logic          job_take,
  output sfe_pkg::job_t job,
  output logic          job_valid
);

  logic          in_valid;
  logic [7:0]    even_r;
  logic [7:0]    odd_r;
  logic          fin_r;
  logic [15:0]   crc_reg;
  logic          at_frame_start;
  logic          advance;
  logic [15:0]   word;
  logic [15:0]   crc_next;
  logic [7:0]    b0;
  logic [7:0]    b1;
  logic [2:0]    n;
  sfe_pkg::job_t job_next;

  assign advance       = in_valid && (!job_valid || job_take);
  assign word_in.ready = !in_valid || advance;

  always_comb begin
    word     = at_frame_start ? {odd_r, even_r} : {even_r, odd_r};
    crc_next = sfe_pkg::crc_word(crc_reg, word);
    if (fin_r) begin
      b0 = at_frame_start ? crc_next[15:8] : crc_next[7:0];
      b1 = at_frame_start ? crc_next[7:0] : crc_next[15:8];
    end else begin
      b0 = at_frame_start ? even_r : odd_r;
      b1 = at_frame_start ? odd_r : even_r;
    end

    job_next = '0;
    n = 3'd0;
    if (at_frame_start) begin
      job_next.bytes[0] = cfg_regs.escape_byte;
      job_next.bytes[1] = cfg_regs.start_byte;
      n = 3'd2;
    end
    job_next.bytes[n] = b0;
    n = n + 3'd1;
    if (b0 == cfg_regs.escape_byte) begin
      job_next.bytes[n] = b0;
      n = n + 3'd1;
    end
    job_next.bytes[n] = b1;
    n = n + 3'd1;
    if (b1 == cfg_regs.escape_byte) begin
      job_next.bytes[n] = b1;
      n = n + 3'd1;
    end
    job_next.count = n;
    job_next.fin   = fin_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      job_valid      <= 1'b0;
      crc_reg        <= 16'h0000;
      at_frame_start <= 1'b1;
    end else begin
      if (word_in.ready) begin
        in_valid <= word_in.valid;
      end
      if (advance) begin
        job_valid      <= 1'b1;
        crc_reg        <= fin_r ? 16'h0000 : crc_next;
        at_frame_start <= fin_r;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_in.valid && word_in.ready) begin
      even_r <= word_in.even_byte;
      odd_r  <= word_in.odd_byte;
      fin_r  <= word_in.final_word;
    end
    if (advance) begin
      job <= job_next;
    end
  end

endmodule

FILE: rtl/core/sfe_byte_serializer.sv
module sfe_byte_serializer (
  input  logic          clk,
  input  logic          rst,
  input  sfe_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_take,
  sfe_out_if.source     byte_out
);

  logic [2:0] idx;
  logic       last;
  logic       beat;

  assign last                = idx == (job.count - 3'd1);
  assign beat                = byte_out.valid && byte_out.ready;
  assign job_take            = beat && last;
  assign byte_out.valid      = job_valid;
  assign byte_out.line_byte  = job.bytes[idx];
  assign byte_out.run_last   = last;
  assign byte_out.frame_done = last && job.fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (beat) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

FILE: rtl/core/serial_frame_encoder_crc16_stuffing_unit.sv
// Channel    Role    Beat carries
// cfg        sink    index (0 escape byte, 1 start byte), data
// word_in    sink    even_byte, odd_byte, final_word
// byte_out   source  line_byte, run_last, frame_done
//
// Each word beat yields two to six byte beats, one per cycle while byte_out is ready;
// the byte serializer sets the rate.
// A word waits in the input register while the previous word's bytes drain, and the
// next word is taken in the cycle its predecessor's last byte leaves.
// Reset is synchronous and returns the CRC to zero, the frame to its start and the
// registers to escape 0x90 and start 0x02. Stalls on byte_out hold every byte in place.
module serial_frame_encoder_crc16_stuffing_unit (
  input  logic      clk,
  input  logic      rst,
  sfe_cfg_if.sink   cfg,
  sfe_in_if.sink    word_in,
  sfe_out_if.source byte_out
);

  sfe_pkg::cfg_t cfg_regs;
  sfe_pkg::job_t job;
  logic          job_valid;
  logic          job_take;

  sfe_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_regs (cfg_regs)
  );

  sfe_word_stage u_word (
    .clk       (clk),
    .rst       (rst),
    .word_in   (word_in),
    .cfg_regs  (cfg_regs),
    .job_take  (job_take),
    .job       (job),
    .job_valid (job_valid)
  );

  sfe_byte_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take),
    .byte_out  (byte_out)
  );

endmodule

FILE: rtl/core/sfe_checker.sv
module sfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] line_byte,
  input logic       run_last,
  input logic       frame_done
);

  // A frame can only close on the last byte of a word.
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_last || !frame_done))
    else $error("frame_done without run_last");

  // Once a byte of a word leaves, the rest of that word stays offered without a gap.
  a_word_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !run_last) |=> out_valid)
    else $error("gap inside a word");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(line_byte)))
    else $error("stalled byte changed");

endmodule

bind serial_frame_encoder_crc16_stuffing_unit sfe_checker u_sfe_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (byte_out.valid),
  .out_ready  (byte_out.ready),
  .line_byte  (byte_out.line_byte),
  .run_last   (byte_out.run_last),
  .frame_done (byte_out.frame_done)
);
